// File: src/assert_macros.svh
// Assertion helpers shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked while out of reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/qts_pkg.sv
package qts_pkg;

  localparam int DELIM_SLOTS = 4;
  localparam int SLOT_MAX    = 4;   // delimiter bytes held by the 32-bit register
  localparam int SLOT_CAP    = (DELIM_SLOTS < SLOT_MAX) ? DELIM_SLOTS : SLOT_MAX;
  localparam int GROUP_MAX   = 4;   // most results one byte can cause

  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] DQUOTE    = 8'h22;
  localparam logic [7:0] TOK_MAX   = 8'hFF;

  typedef enum logic [1:0] {
    MODE_SKIP,
    MODE_TOKEN,
    MODE_RAW,
    MODE_RAW_SWALLOW
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_END,
    KIND_EOI,
    KIND_RSVD
  } kind_t;

  typedef enum logic [1:0] {
    REG_DELIM_CHARS,
    REG_DELIM_COUNT,
    REG_MAX_TOKENS,
    REG_USE_QUOTES
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] delim_chars;
    logic [2:0]  delim_count;
    logic [7:0]  max_tokens;
    logic        use_quotes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] ch;
    kind_t      kind;
    logic [7:0] num;
  } res_t;

  // All results of one input byte; slots above last_idx are unused.
  typedef struct packed {
    res_t [GROUP_MAX-1:0] slot;
    logic [1:0]           last_idx;
  } group_t;

  function automatic logic is_delim(logic [7:0] c, cfg_t cfg);
    logic       hit;
    logic [2:0] n;
    hit = 1'b0;
    n   = (cfg.delim_count > 3'(SLOT_CAP)) ? 3'(SLOT_CAP) : cfg.delim_count;
    for (int i = 0; i < SLOT_CAP; i++) begin
      if ((3'(i) < n) && (cfg.delim_chars[8*i +: 8] == c)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic limit_hit(logic [7:0] t, logic [7:0] mt);
    return (mt != 8'd0) && (t >= (mt - 8'd1));
  endfunction

endpackage

// File: src/quoted_token_splitter.sv
// Channel   Direction  Handshake            Payload
// input     in         push / full          in_char, in_final_char
// result    out        pop / empty          out_char, out_kind, out_token_number,
//                                           out_run_last
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A byte is taken at any edge with push high and full low; the front scans it in
// that cycle and writes its results (none to four) to the queue as one group.
// Its results go through the queue into the back's output register; the back then
// hands out one result per cycle while the receiver pops, so a byte with k results takes k pops.
// full rises once QUEUE_DEPTH groups wait, so a slow receiver stalls the input.
// Synchronous reset empties the queue, restores registers and scan state; cfg_ready is 1.

module quoted_token_splitter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input requests
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char,
  input  logic        in_final_char,
  // results
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_token_number,
  output logic        out_run_last,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  qts_pkg::cfg_t   cfg_r;
  qts_pkg::group_t grp_in;
  qts_pkg::group_t grp_head;
  logic            grp_push;
  logic            grp_pop;
  logic            grp_avail;
  logic            acc;

  assign cfg_ready = 1'b1;
  assign acc       = push && !full;

  // Register file; the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delim_chars <= 32'd32;
      cfg_r.delim_count <= 3'd1;
      cfg_r.max_tokens  <= 8'd0;
      cfg_r.use_quotes  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (qts_pkg::reg_idx_t'(cfg_index))
        qts_pkg::REG_DELIM_CHARS: cfg_r.delim_chars <= cfg_data;
        qts_pkg::REG_DELIM_COUNT: cfg_r.delim_count <= cfg_data[2:0];
        qts_pkg::REG_MAX_TOKENS:  cfg_r.max_tokens  <= cfg_data[7:0];
        qts_pkg::REG_USE_QUOTES:  cfg_r.use_quotes  <= cfg_data[0];
      endcase
    end
  end

  // Front: scan state and result grouping, one byte per cycle while the queue is not full.
  qts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .in_char    (in_char),
    .final_char (in_final_char),
    .cfg        (cfg_r),
    .grp_valid  (grp_push),
    .grp        (grp_in)
  );

  // Groups waiting for the back; full here backpressures the input.
  qts_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (grp_push),
    .wdata    (grp_in),
    .full     (full),
    .pop      (grp_pop),
    .rdata    (grp_head),
    .nonempty (grp_avail)
  );

  // Back: unpacks each group into single results behind an output register.
  qts_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .grp_valid        (grp_avail),
    .grp              (grp_head),
    .grp_pop          (grp_pop),
    .pop              (pop),
    .empty            (empty),
    .out_char         (out_char),
    .out_kind         (out_kind),
    .out_token_number (out_token_number),
    .out_run_last     (out_run_last)
  );

endmodule

// File: src/qts_front.sv
`include "assert_macros.svh"

module qts_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        in_char,
  input  logic              final_char,
  input  qts_pkg::cfg_t     cfg,
  output logic              grp_valid,
  output qts_pkg::group_t   grp
);

  qts_pkg::mode_t mode_r, mode_nxt;
  logic           inq_r, inq_nxt;
  logic           esc_r, esc_nxt;
  logic           has_r, has_nxt;
  logic [7:0]     tok_r, tok_nxt;

  qts_pkg::res_t [qts_pkg::GROUP_MAX-1:0] rs;
  logic [2:0] n;
  logic       dlm;
  logic       do_tok;
  logic       closing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= qts_pkg::MODE_SKIP;
      inq_r  <= 1'b0;
      esc_r  <= 1'b0;
      has_r  <= 1'b0;
      tok_r  <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      inq_r  <= inq_nxt;
      esc_r  <= esc_nxt;
      has_r  <= has_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    inq_nxt  = inq_r;
    esc_nxt  = esc_r;
    has_nxt  = has_r;
    tok_nxt  = tok_r;
    rs       = '0;
    n        = '0;
    do_tok   = 1'b0;
    closing  = 1'b0;
    dlm      = qts_pkg::is_delim(in_char, cfg);

    unique case (mode_r)
      qts_pkg::MODE_SKIP: begin
        if (!dlm) begin
          if (qts_pkg::limit_hit(tok_nxt, cfg.max_tokens)) begin
            mode_nxt    = qts_pkg::MODE_RAW;
            rs[n[1:0]]  = '{ch: in_char, kind: qts_pkg::KIND_BYTE, num: tok_nxt};
            n           = n + 3'd1;
            has_nxt     = 1'b1;
          end else begin
            mode_nxt = qts_pkg::MODE_TOKEN;
            do_tok   = 1'b1;
          end
        end
      end
      qts_pkg::MODE_TOKEN: begin
        do_tok = 1'b1;
      end
      qts_pkg::MODE_RAW_SWALLOW: begin
        mode_nxt = qts_pkg::MODE_RAW;
        if (!dlm) begin
          rs[n[1:0]] = '{ch: in_char, kind: qts_pkg::KIND_BYTE, num: tok_nxt};
          n          = n + 3'd1;
          has_nxt    = 1'b1;
        end
      end
      qts_pkg::MODE_RAW: begin
        rs[n[1:0]] = '{ch: in_char, kind: qts_pkg::KIND_BYTE, num: tok_nxt};
        n          = n + 3'd1;
        has_nxt    = 1'b1;
      end
    endcase

    if (do_tok) begin
      priority if (dlm && !inq_nxt) begin
        // unquoted delimiter closes the token
        if (has_nxt) begin
          rs[n[1:0]] = '{ch: 8'd0, kind: qts_pkg::KIND_END, num: tok_nxt};
          n          = n + 3'd1;
          if (tok_nxt != qts_pkg::TOK_MAX) tok_nxt = tok_nxt + 8'd1;
        end
        has_nxt  = 1'b0;
        esc_nxt  = 1'b0;
        mode_nxt = qts_pkg::limit_hit(tok_nxt, cfg.max_tokens) ?
                   qts_pkg::MODE_RAW : qts_pkg::MODE_SKIP;
      end else if (!cfg.use_quotes) begin
        rs[n[1:0]] = '{ch: in_char, kind: qts_pkg::KIND_BYTE, num: tok_nxt};
        n          = n + 3'd1;
        has_nxt    = 1'b1;
      end else if (in_char == qts_pkg::BACKSLASH) begin
        if (esc_nxt) begin
          rs[n[1:0]] = '{ch: in_char, kind: qts_pkg::KIND_BYTE, num: tok_nxt};
          n          = n + 3'd1;
          has_nxt    = 1'b1;
          esc_nxt    = 1'b0;
        end else begin
          esc_nxt = 1'b1;
        end
      end else if (in_char == qts_pkg::DQUOTE) begin
        if (esc_nxt) begin
          rs[n[1:0]] = '{ch: in_char, kind: qts_pkg::KIND_BYTE, num: tok_nxt};
          n          = n + 3'd1;
          has_nxt    = 1'b1;
          esc_nxt    = 1'b0;
        end else begin
          closing = inq_nxt;
          inq_nxt = !inq_nxt;
          if (has_nxt) begin
            rs[n[1:0]] = '{ch: 8'd0, kind: qts_pkg::KIND_END, num: tok_nxt};
            n          = n + 3'd1;
            if (tok_nxt != qts_pkg::TOK_MAX) tok_nxt = tok_nxt + 8'd1;
          end
          has_nxt = 1'b0;
          esc_nxt = 1'b0;
          if (qts_pkg::limit_hit(tok_nxt, cfg.max_tokens)) begin
            mode_nxt = closing ? qts_pkg::MODE_RAW_SWALLOW : qts_pkg::MODE_RAW;
          end else begin
            mode_nxt = qts_pkg::MODE_SKIP;
          end
        end
      end else begin
        // backslash before an ordinary byte is kept
        if (esc_nxt) begin
          rs[n[1:0]] = '{ch: qts_pkg::BACKSLASH, kind: qts_pkg::KIND_BYTE, num: tok_nxt};
          n          = n + 3'd1;
          esc_nxt    = 1'b0;
        end
        rs[n[1:0]] = '{ch: in_char, kind: qts_pkg::KIND_BYTE, num: tok_nxt};
        n          = n + 3'd1;
        has_nxt    = 1'b1;
      end
    end

    if (final_char) begin
      if (has_nxt) begin
        rs[n[1:0]] = '{ch: 8'd0, kind: qts_pkg::KIND_END, num: tok_nxt};
        n          = n + 3'd1;
        if (tok_nxt != qts_pkg::TOK_MAX) tok_nxt = tok_nxt + 8'd1;
      end
      rs[n[1:0]] = '{ch: 8'd0, kind: qts_pkg::KIND_EOI, num: tok_nxt};
      n          = n + 3'd1;
      mode_nxt   = qts_pkg::MODE_SKIP;
      inq_nxt    = 1'b0;
      esc_nxt    = 1'b0;
      has_nxt    = 1'b0;
      tok_nxt    = '0;
    end
  end

  assign grp_valid    = acc && (n != 3'd0);
  assign grp.slot     = rs;
  assign grp.last_idx = 2'(n - 3'd1);

  // swallow mode is only entered on a closing quote
  `ASSERT_IMP(a_swallow_unquoted, clk, rst_n, mode_r == qts_pkg::MODE_RAW_SWALLOW, !inq_r)
  `ASSERT_IMP(a_skip_clean, clk, rst_n, mode_r == qts_pkg::MODE_SKIP, !has_r && !esc_r)

endmodule

// File: src/qts_fifo.sv
`include "assert_macros.svh"

module qts_fifo #(
  parameter int Depth = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  qts_pkg::group_t wdata,
  output logic            full,
  input  logic            pop,
  output qts_pkg::group_t rdata,
  output logic            nonempty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  qts_pkg::group_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign rdata    = mem_r[rd_ptr_r];
  assign full     = (cnt_r == CntW'(Depth));
  assign nonempty = (cnt_r != '0);

  `ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full || pop)
  `ASSERT_IMP(a_no_underflow, clk, rst_n, pop, cnt_r != '0)

endmodule

// File: src/qts_back.sv
`include "assert_macros.svh"

module qts_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            grp_valid,
  input  qts_pkg::group_t grp,
  output logic            grp_pop,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_char,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_token_number,
  output logic            out_run_last
);

  logic          out_valid_r;
  qts_pkg::res_t out_res_r;
  logic          out_last_r;
  logic [1:0]    idx_r;
  logic          load;
  logic          at_last;

  assign at_last = (idx_r == grp.last_idx);
  assign load    = grp_valid && (!out_valid_r || pop);
  assign grp_pop = load && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= at_last ? 2'd0 : idx_r + 2'd1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= grp.slot[idx_r];
      out_last_r <= at_last;
    end
  end

  assign empty            = !out_valid_r;
  assign out_char         = out_res_r.ch;
  assign out_kind         = out_res_r.kind;
  assign out_token_number = out_res_r.num;
  assign out_run_last     = out_last_r;

  `ASSERT_IMP(a_idx_in_group, clk, rst_n, grp_valid, idx_r <= grp.last_idx)
  `ASSERT_IMP(a_mark_no_char, clk, rst_n,
              out_valid_r && (out_res_r.kind != qts_pkg::KIND_BYTE), out_res_r.ch == 8'd0)

endmodule
